/* sv/dlesfr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlesfr_pkg
// Shared types and constants for the DLE-stuffed frame receiver.
// ----------------------------------------------------------------------------
package dlesfr_pkg;

    localparam int MAX_LEN = 1024;
    localparam int LEN_W   = 11;
    localparam int ADDR_W  = 32;

    localparam logic [7:0] DLE_CODE = 8'h10;
    localparam logic [7:0] STX_CODE = 8'h02;
    localparam logic [7:0] ETX_CODE = 8'h03;

    // Register indexes on the configuration port
    localparam logic CFG_OWN_ADDRESS = 1'b0;
    localparam logic CFG_MAX_LENGTH  = 1'b1;

    typedef enum logic [2:0] {
        KIND_DATA       = 3'd0,
        KIND_DONE       = 3'd1,
        KIND_WRONG_DEST = 3'd2,
        KIND_BAD_ESCAPE = 3'd3,
        KIND_FULL       = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        PH_HUNT     = 3'd0,
        PH_HUNT_DLE = 3'd1,
        PH_HEADER   = 3'd2,
        PH_PAYLOAD  = 3'd3,
        PH_ESCAPE   = 3'd4
    } phase_t;

endpackage

/* sv/dle_stuffed_frame_receiver.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dle_stuffed_frame_receiver
// Hunts DLE STX, takes an 8-byte raw header (source, destination IDs),
// destuffs payload and reports frame end, rejection, bad escape or full.
// ----------------------------------------------------------------------------
// Path: an accepted input word passes through the input register, then
//   the result register, before its result word reaches the output.
// Throughput: one word per cycle; in_stall rises only when a result waits.
// Reset: rst_n is asynchronous, active low; the receiver comes up hunting,
//   own_address = 0, max_length = 1024, both pipeline stages empty.
module dle_stuffed_frame_receiver (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [dlesfr_pkg::ADDR_W-1:0] cfg_data,
    // input channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [7:0]                    rx_byte,
    // output channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [2:0]                    kind,
    output logic [7:0]                    data_byte,
    output logic [dlesfr_pkg::LEN_W-1:0]  frame_length,
    output logic [31:0]                   sender_id
);
    import dlesfr_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0] own_address_reg;
    logic [LEN_W-1:0]  max_length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_address_reg <= '0;
            max_length_reg  <= LEN_W'(MAX_LEN);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_OWN_ADDRESS: own_address_reg <= cfg_data;
                CFG_MAX_LENGTH:  max_length_reg  <= cfg_data[LEN_W-1:0];
                default:         ;
            endcase
        end
    end

    // Effective limit saturates at MAX_LEN
    logic [LEN_W-1:0] limit;
    assign limit = (max_length_reg > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : max_length_reg;

    // ------------------------------------------------------------------
    // Pipeline handshake: input register feeds the result register.
    // Stage 1 drains whenever the result register is empty or being taken.
    // ------------------------------------------------------------------
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       out_valid_reg;
    logic       s1_advance;
    logic       in_accept;
    logic       s1_fire;

    assign s1_advance = !out_valid_reg || !out_stall;
    assign in_stall   = s1_valid_reg && !s1_advance;
    assign in_accept  = in_valid && !in_stall;
    assign s1_fire    = s1_valid_reg && s1_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_byte_reg <= rx_byte;
        end
    end

    // ------------------------------------------------------------------
    // Frame state
    // ------------------------------------------------------------------
    phase_t           phase_reg, phase_next;
    logic [3:0]       header_count_reg, header_count_next;
    logic [31:0]      source_shift_reg, source_shift_next;
    logic [31:0]      dest_shift_reg, dest_shift_next;
    logic [LEN_W-1:0] payload_count_reg, payload_count_next;

    logic [7:0]       b;
    logic [3:0]       hc_inc;
    logic [LEN_W-1:0] count_inc;

    assign b         = s1_byte_reg;
    assign hc_inc    = header_count_reg + 4'd1;
    assign count_inc = payload_count_reg + LEN_W'(1);

    // Next-state logic
    always_comb
    begin
        phase_next         = phase_reg;
        header_count_next  = header_count_reg;
        source_shift_next  = source_shift_reg;
        dest_shift_next    = dest_shift_reg;
        payload_count_next = payload_count_reg;
        case (phase_reg)
            PH_HUNT_DLE:
            begin
                if (b == STX_CODE)
                begin
                    phase_next         = PH_HEADER;
                    header_count_next  = '0;
                    source_shift_next  = '0;
                    dest_shift_next    = '0;
                    payload_count_next = '0;
                end
                else if (b != DLE_CODE)
                begin
                    phase_next = PH_HUNT;
                end
            end
            PH_HEADER:
            begin
                // little-endian: newest byte lands on top
                if (header_count_reg < 4'd4)
                    source_shift_next = {b, source_shift_reg[31:8]};
                else
                    dest_shift_next = {b, dest_shift_reg[31:8]};
                header_count_next = hc_inc;
                if (hc_inc >= 4'd8)
                begin
                    header_count_next = '0;
                    if (dest_shift_next != own_address_reg)
                        phase_next = PH_HUNT;
                    else
                        phase_next = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                if (payload_count_reg >= limit)
                    phase_next = PH_HUNT;
                else if (b == DLE_CODE)
                    phase_next = PH_ESCAPE;
                else
                    payload_count_next = count_inc;
            end
            PH_ESCAPE:
            begin
                if (b == DLE_CODE)
                begin
                    phase_next         = PH_PAYLOAD;
                    payload_count_next = count_inc;
                end
                else
                begin
                    phase_next = PH_HUNT;
                end
            end
            default:
            begin
                phase_next = (b == DLE_CODE) ? PH_HUNT_DLE : PH_HUNT;
            end
        endcase
    end

    // Result logic
    logic             res_valid;
    kind_t            res_kind;
    logic [7:0]       res_data;
    logic [LEN_W-1:0] res_len;

    always_comb
    begin
        res_valid = 1'b0;
        res_kind  = KIND_DATA;
        res_data  = '0;
        res_len   = '0;
        case (phase_reg)
            PH_HEADER:
            begin
                if (hc_inc >= 4'd8 && dest_shift_next != own_address_reg)
                begin
                    res_valid = 1'b1;
                    res_kind  = KIND_WRONG_DEST;
                end
            end
            PH_PAYLOAD:
            begin
                if (payload_count_reg >= limit)
                begin
                    res_valid = 1'b1;
                    res_kind  = KIND_FULL;
                    res_len   = payload_count_reg;
                end
                else if (b != DLE_CODE)
                begin
                    res_valid = 1'b1;
                    res_kind  = KIND_DATA;
                    res_data  = b;
                    res_len   = count_inc;
                end
            end
            PH_ESCAPE:
            begin
                res_valid = 1'b1;
                if (b == ETX_CODE)
                begin
                    res_kind = KIND_DONE;
                    res_len  = payload_count_reg;
                end
                else if (b == DLE_CODE)
                begin
                    res_kind = KIND_DATA;
                    res_data = b;
                    res_len  = count_inc;
                end
                else
                begin
                    res_kind = KIND_BAD_ESCAPE;
                    res_len  = payload_count_reg;
                end
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_HUNT;
            header_count_reg  <= '0;
            source_shift_reg  <= '0;
            dest_shift_reg    <= '0;
            payload_count_reg <= '0;
        end
        else if (s1_fire)
        begin
            phase_reg         <= phase_next;
            header_count_reg  <= header_count_next;
            source_shift_reg  <= source_shift_next;
            dest_shift_reg    <= dest_shift_next;
            payload_count_reg <= payload_count_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic [2:0]       kind_reg;
    logic [7:0]       data_byte_reg;
    logic [LEN_W-1:0] frame_length_reg;
    logic [31:0]      sender_id_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire && res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && res_valid)
        begin
            kind_reg         <= res_kind;
            data_byte_reg    <= res_data;
            frame_length_reg <= res_len;
            sender_id_reg    <= source_shift_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign data_byte    = data_byte_reg;
    assign frame_length = frame_length_reg;
    assign sender_id    = sender_id_reg;

endmodule

/* sv/dlesfr_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlesfr_checker
// Port-level checks for the DLE-stuffed frame receiver, bound to the top.
// ----------------------------------------------------------------------------
module dlesfr_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [2:0]                   kind,
    input logic [7:0]                   data_byte,
    input logic [dlesfr_pkg::LEN_W-1:0] frame_length,
    input logic [31:0]                  sender_id
);
    import dlesfr_pkg::*;

    // held word stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) && $stable(data_byte)
            && $stable(frame_length) && $stable(sender_id))
        else $error("result word changed while stalled");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> kind <= KIND_FULL)
        else $error("kind code out of range");

    a_data_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_DATA |-> frame_length != '0
            && frame_length <= LEN_W'(MAX_LEN))
        else $error("payload word with bad length");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_WRONG_DEST |-> frame_length == '0 && data_byte == '0)
        else $error("rejection carries length or data");

    a_ctrl_nodata: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_DATA |-> data_byte == '0)
        else $error("control word carries data");

endmodule

bind dle_stuffed_frame_receiver dlesfr_checker u_dlesfr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .data_byte    (data_byte),
    .frame_length (frame_length),
    .sender_id    (sender_id)
);

/* tb/sv/dle_stuffed_frame_receiver_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dle_stuffed_frame_receiver_tb
// Self-checking bench for the DLE STX/ETX deframer. A short directed table
// hits the corner cases, then random frames (mostly well formed, some broken,
// some line noise) run under several register settings. Both handshakes idle
// and stall at random. Every output word is compared, in order, against a
// local predictor of the receiver or the word spelled out in a directed row.
// ----------------------------------------------------------------------------
module dle_stuffed_frame_receiver_tb;
    import dlesfr_pkg::*;

    // One output word of the receiver
    typedef struct packed {
        kind_t              kind;
        logic [7:0]         data;
        logic [LEN_W-1:0]   len;
        logic [ADDR_W-1:0]  sender;
    } rx_event_t;

    typedef enum logic {
        ROW_BYTE = 1'b0,
        ROW_REG  = 1'b1
    } row_op_t;

    // Directed table row: a link byte or a register write.
    // typed = 1 means the expected word is spelled out in the row.
    typedef struct packed {
        row_op_t            op;
        logic               idx;
        logic [31:0]        value;
        logic               typed;
        rx_event_t          ev;
    } stim_row_t;

    // DUT ports
    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic                   cfg_index;
    logic [ADDR_W-1:0]      cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    logic [7:0]             rx_byte;
    logic                   out_valid;
    logic                   out_stall;
    logic [2:0]             kind;
    logic [7:0]             data_byte;
    logic [LEN_W-1:0]       frame_length;
    logic [31:0]            sender_id;

    // Predictor state and register copies (reset values)
    phase_t                 rx_phase   = PH_HUNT;
    logic [3:0]             hdr_count  = '0;
    logic [31:0]            src_id     = '0;
    logic [31:0]            dst_id     = '0;
    logic [LEN_W-1:0]       pay_count  = '0;
    logic [31:0]            own_addr_m = '0;
    logic [LEN_W-1:0]       max_len_m  = LEN_W'(MAX_LEN);

    rx_event_t              events_due[$];
    stim_row_t              stim_rows[$];
    int                     words_sent  = 0;
    int                     fail_count  = 0;
    bit                     tx_burst    = 1'b0;
    bit                     rx_burst    = 1'b0;

    dle_stuffed_frame_receiver dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .data_byte    (data_byte),
        .frame_length (frame_length),
        .sender_id    (sender_id)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor: advance the deframer by one link byte. Returns 1 when
    // the byte produces an output word, which is left in ev.
    // ------------------------------------------------------------------
    function automatic bit deframe_byte(input logic [7:0] b, output rx_event_t ev);
        int limit;
        bit hit;
        // length limit saturates at MAX_LEN
        limit = (max_len_m > MAX_LEN) ? MAX_LEN : int'(max_len_m);
        hit = 1'b0;
        ev = '0;
        case (rx_phase)
            PH_HUNT_DLE:
            begin
                if (b == STX_CODE)
                begin
                    rx_phase  = PH_HEADER;
                    hdr_count = '0;
                    src_id    = '0;
                    dst_id    = '0;
                    pay_count = '0;
                end
                else if (b != DLE_CODE)
                    rx_phase = PH_HUNT;   // DLE again keeps the pair alive
            end
            PH_HEADER:
            begin
                // header is raw, little endian: shift in from the top
                if (hdr_count < 4)
                    src_id = {b, src_id[31:8]};
                else
                    dst_id = {b, dst_id[31:8]};
                hdr_count = hdr_count + 4'd1;
                if (hdr_count >= 8)
                begin
                    hdr_count = '0;
                    if (dst_id != own_addr_m)
                    begin
                        rx_phase = PH_HUNT;
                        hit      = 1'b1;
                        ev.kind  = KIND_WRONG_DEST;
                    end
                    else
                        rx_phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                if (pay_count >= limit)
                begin
                    // byte dropped whatever it is
                    rx_phase = PH_HUNT;
                    hit      = 1'b1;
                    ev.kind  = KIND_FULL;
                    ev.len   = pay_count;
                end
                else if (b == DLE_CODE)
                    rx_phase = PH_ESCAPE;
                else
                begin
                    pay_count = pay_count + 1'b1;
                    hit       = 1'b1;
                    ev.kind   = KIND_DATA;
                    ev.data   = b;
                    ev.len    = pay_count;
                end
            end
            PH_ESCAPE:
            begin
                hit = 1'b1;
                if (b == ETX_CODE)
                begin
                    rx_phase = PH_HUNT;
                    ev.kind  = KIND_DONE;
                    ev.len   = pay_count;
                end
                else if (b == DLE_CODE)
                begin
                    rx_phase  = PH_PAYLOAD;
                    pay_count = pay_count + 1'b1;
                    ev.kind   = KIND_DATA;
                    ev.data   = b;
                    ev.len    = pay_count;
                end
                else
                begin
                    rx_phase = PH_HUNT;
                    ev.kind  = KIND_BAD_ESCAPE;
                    ev.len   = pay_count;
                end
            end
            default:
                rx_phase = (b == DLE_CODE) ? PH_HUNT_DLE : PH_HUNT;
        endcase
        ev.sender = src_id;
        return hit;
    endfunction

    // ------------------------------------------------------------------
    // Directed table builders
    // ------------------------------------------------------------------
    function automatic void add_byte(input logic [7:0] b);
        stim_row_t r;
        r = '0;
        r.op = ROW_BYTE;
        r.value = {24'd0, b};
        stim_rows.push_back(r);
    endfunction

    function automatic void add_byte_exp(input logic [7:0] b, input kind_t k,
                                         input logic [7:0] d, input int len,
                                         input logic [31:0] sender);
        stim_row_t r;
        r = '0;
        r.op        = ROW_BYTE;
        r.value     = {24'd0, b};
        r.typed     = 1'b1;
        r.ev.kind   = k;
        r.ev.data   = d;
        r.ev.len    = LEN_W'(len);
        r.ev.sender = sender;
        stim_rows.push_back(r);
    endfunction

    function automatic void add_reg(input logic idx, input logic [31:0] val);
        stim_row_t r;
        r = '0;
        r.op    = ROW_REG;
        r.idx   = idx;
        r.value = val;
        stim_rows.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // Input side. Random gap before each word (none in a burst), then hold
    // the word until it is taken. Prediction runs at the accepting edge;
    // a typed row overrides the predicted word.
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic typed,
                             input rx_event_t typed_ev);
        int gap;
        bit hit;
        rx_event_t ev;
        gap = tx_burst ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (in_stall);
        hit = deframe_byte(b, ev);
        if (typed)
            events_due.push_back(typed_ev);
        else if (hit)
            events_due.push_back(ev);
        words_sent++;
    endtask

    task automatic send(input logic [7:0] b);
        send_byte(b, 1'b0, '0);
    endtask

    // Sender holds off until every expected word is out, then gives the
    // two pipeline stages time to settle (bytes with no result).
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (events_due.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_OWN_ADDRESS)
            own_addr_m = val;
        else
            max_len_m = val[LEN_W-1:0];
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // One random frame: some noise, DLE STX, raw header, stuffed payload
    // and an ending that is mostly DLE ETX, sometimes a bad escape, a
    // dangling DLE or nothing at all.
    // ------------------------------------------------------------------
    task automatic send_frame();
        int n;
        int pay_len;
        int ending;
        logic [31:0] src;
        logic [31:0] dst;
        logic [7:0] b;
        n = $urandom_range(0, 3);
        repeat (n) send(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 3) == 0)
            send(DLE_CODE);                // repeated DLE while hunting
        send(DLE_CODE);
        send(STX_CODE);

        src = $urandom();
        if ($urandom_range(0, 3) == 0)
            src[8*$urandom_range(0, 3) +: 8] = DLE_CODE;   // raw DLE in header
        case ($urandom_range(0, 7))
            0: dst = $urandom();
            1: dst = own_addr_m ^ (32'h1 << $urandom_range(0, 31));
            default: dst = own_addr_m;
        endcase
        for (int i = 0; i < 4; i++)
            send(src[8*i +: 8]);
        for (int i = 0; i < 4; i++)
            send(dst[8*i +: 8]);

        // mostly short frames, now and then a longer one
        if ($urandom_range(0, 7) == 0)
            pay_len = $urandom_range(13, 40);
        else
            pay_len = $urandom_range(0, 12);
        repeat (pay_len)
        begin
            b = ($urandom_range(0, 4) == 0) ? DLE_CODE : 8'($urandom_range(0, 255));
            send(b);
            if (b == DLE_CODE)
                send(DLE_CODE);
        end

        ending = $urandom_range(0, 9);
        if (ending < 7)
        begin
            send(DLE_CODE);
            send(ETX_CODE);
        end
        else if (ending == 7)
        begin
            b = 8'($urandom_range(0, 255));
            if (b == ETX_CODE || b == DLE_CODE)
                b = 8'hA5;
            send(DLE_CODE);
            send(b);
        end
        else if (ending == 8)
            send(DLE_CODE);                // frame left open
    endtask

    // ------------------------------------------------------------------
    // Output side: random stall between words, compare each taken word
    // with the oldest expectation.
    // ------------------------------------------------------------------
    initial
    begin : result_check
        int hold;
        rx_event_t exp_ev;
        hold = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (events_due.size() == 0)
                begin
                    $error("unexpected word: kind %0d, data_byte %0h, frame_length %0d",
                           kind, data_byte, frame_length);
                    fail_count++;
                end
                else
                begin
                    exp_ev = events_due.pop_front();
                    if (kind !== exp_ev.kind)
                    begin
                        $error("kind: expected %0d, got %0d", exp_ev.kind, kind);
                        fail_count++;
                    end
                    if (data_byte !== exp_ev.data)
                    begin
                        $error("data_byte: expected %0h, got %0h", exp_ev.data, data_byte);
                        fail_count++;
                    end
                    if (frame_length !== exp_ev.len)
                    begin
                        $error("frame_length: expected %0d, got %0d",
                               exp_ev.len, frame_length);
                        fail_count++;
                    end
                    if (sender_id !== exp_ev.sender)
                    begin
                        $error("sender_id: expected %0h, got %0h", exp_ev.sender, sender_id);
                        fail_count++;
                    end
                end
                hold = rx_burst ? 0 : $urandom_range(0, 11);
            end
            else if (hold > 0)
                hold--;
            out_stall <= (hold != 0);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        stim_row_t row;
        int phase_no;
        int phase_end;
        logic [LEN_W-1:0] ml;
        logic [31:0] own;

        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_OWN_ADDRESS;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        rx_byte   <= '0;

        // Frame 1, reset registers (own address 0): repeated DLE before
        // STX, a DLE inside the raw source ID, one stuffed DLE, then a
        // bad escape. Source ID 0x8000FF10.
        add_byte(DLE_CODE);
        add_byte(DLE_CODE);
        add_byte(STX_CODE);
        add_byte(DLE_CODE);
        add_byte(8'hFF);
        add_byte(8'h00);
        add_byte(8'h80);
        add_byte(8'h00);
        add_byte(8'h00);
        add_byte(8'h00);
        add_byte(8'h00);
        add_byte(DLE_CODE);
        add_byte_exp(DLE_CODE, KIND_DATA, DLE_CODE, 1, 32'h8000FF10);
        add_byte(DLE_CODE);
        add_byte_exp(8'hFF, KIND_BAD_ESCAPE, 8'h00, 1, 32'h8000FF10);
        // Frame 2: own address changed before the last header byte,
        // limit cut to zero once in payload, so the first byte is dropped.
        add_byte(DLE_CODE);
        add_byte(STX_CODE);
        add_byte(8'h01);
        add_byte(8'h02);
        add_byte(8'h03);
        add_byte(8'h04);
        add_byte(8'hFF);
        add_byte(8'hFF);
        add_byte(8'hFF);
        add_reg(CFG_OWN_ADDRESS, 32'hFFFF_FFFF);
        add_byte(8'hFF);
        add_reg(CFG_MAX_LENGTH, 32'd0);
        add_byte_exp(8'h00, KIND_FULL, 8'h00, 0, 32'h0403_0201);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_rows[i])
        begin
            row = stim_rows[i];
            if (row.op == ROW_REG)
            begin
                wait_drained();
                write_reg(row.idx, row.value);
            end
            else
                send_byte(row.value[7:0], row.typed, row.ev);
        end

        // Random phases. Each starts idle: new register settings (the
        // extremes first), then frames; the receiver may still be mid-frame
        // from the previous phase when the registers change.
        phase_no = 0;
        while (words_sent < 926)
        begin
            tx_burst = ($urandom_range(0, 3) == 0);
            rx_burst = ($urandom_range(0, 3) == 0);
            wait_drained();
            case ((phase_no < 8) ? phase_no : $urandom_range(0, 11))
                0: ml = 11'd2047;          // above MAX_LEN, saturates
                1: ml = 11'd0;
                2: ml = 11'd1;
                3: ml = LEN_W'(MAX_LEN);
                4: ml = 11'd2;
                5: ml = 11'd16;
                6: ml = 11'd3;
                7: ml = 11'd5;
                default: ml = LEN_W'($urandom_range(1, 40));
            endcase
            case (phase_no % 5)
                0: own = 32'h0000_0000;
                1: own = 32'hFFFF_FFFF;
                2: own = 32'h1010_1010;
                3: own = 32'h0310_0210;
                default: own = $urandom();
            endcase
            write_reg(CFG_MAX_LENGTH, {21'd0, ml});
            write_reg(CFG_OWN_ADDRESS, own);
            phase_end = words_sent + 80;
            while (words_sent < phase_end)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    // line noise rich in control codes
                    repeat (30)
                    begin
                        case ($urandom_range(0, 3))
                            0: send(DLE_CODE);
                            1: send(STX_CODE);
                            2: send(ETX_CODE);
                            default: send(8'($urandom_range(0, 255)));
                        endcase
                    end
                end
                else
                    send_frame();
            end
            phase_no++;
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Run limit, far above the slowest legal run
    initial
    begin : watchdog
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

/* files.f */
sv/dlesfr_pkg.sv
sv/dle_stuffed_frame_receiver.sv
sv/dlesfr_checker.sv
tb/sv/dle_stuffed_frame_receiver_tb.sv
